// ===== hw/rtl/fee_pkg.sv =====
// fee_pkg: grid geometry, derived widths, codes and the color palette
// shared by the fire effect frame engine modules; depends on nothing
`default_nettype none

package fee_pkg;

  // grid geometry
  localparam int GRID_WIDTH  = 240;
  localparam int GRID_HEIGHT = 320;
  localparam int TOP_ROW     = 80;
  localparam int CELLS       = GRID_WIDTH * GRID_HEIGHT;

  // derived widths
  localparam int IDX_W   = $clog2(CELLS);
  localparam int X_W     = $clog2(GRID_WIDTH);
  localparam int Y_W     = $clog2(GRID_HEIGHT);
  localparam int SADDR_W = IDX_W + 2;
  localparam int CELL_W  = 8;
  localparam int ACC_W   = 10;

  // port field widths
  localparam int PIXEL_ADDR_W = 17;
  localparam int COLOR_W      = 16;
  localparam int CFG_INDEX_W  = 4;
  localparam int CFG_DATA_W   = 32;
  localparam int WIND_W       = 6;
  localparam int RNG_W        = 32;

  localparam int CMP_W = ((IDX_W > PIXEL_ADDR_W) ? IDX_W : PIXEL_ADDR_W) + 1;

  // random generator
  localparam logic [RNG_W-1:0] LCG_MUL = 32'h0808_8405;

  // floor(s / 3) = (s * DIV3_MUL) >> DIV3_SHIFT for s up to 3 * 255
  localparam logic [ACC_W-1:0] DIV3_MUL   = 10'd683;
  localparam int               DIV3_SHIFT = 11;
  localparam int               PROD_W     = 2 * ACC_W;

  localparam logic signed [SADDR_W-1:0] CELLS_S = SADDR_W'(CELLS);

  // command codes
  localparam logic CMD_ADVANCE = 1'b0;
  localparam logic CMD_READ    = 1'b1;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_WIND_OFFSET  = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_SEED = 4'd1;

  // shared unit control
  typedef enum logic [1:0] {
    ALU_HOLD,
    ALU_LOAD,
    ALU_ADD
  } alu_op_t;

  typedef struct packed {
    alu_op_t op;
    logic    three_tap;
  } alu_ctrl_t;

  // heat index to rgb565
  function automatic logic [COLOR_W-1:0] palette(input logic [CELL_W-1:0] h);
    logic [7:0]         r;
    logic [7:0]         g;
    logic [7:0]         b;
    logic [COLOR_W-1:0] color;
    r = 8'd0;
    g = 8'd0;
    b = 8'd0;
    if (h == 8'd0 || h == 8'd255) begin
      color = '0;
    end else if (h <= 8'd84) begin
      r = (h - 8'd1) * 8'd3;
      color = {r[7:3], g[7:2], b[7:3]};
    end else if (h <= 8'd168) begin
      r = 8'd249;
      g = (h - 8'd85) * 8'd3;
      color = {r[7:3], g[7:2], b[7:3]};
    end else if (h <= 8'd252) begin
      r = 8'd249;
      g = 8'd249;
      b = (h - 8'd169) * 8'd3;
      color = {r[7:3], g[7:2], b[7:3]};
    end else begin
      color = 16'hFFFF;
    end
    return color;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fee_if.sv =====
// fee_if: valid/ready channel interfaces for items, results and config writes
// depends on fee_pkg for field widths
`default_nettype none

interface fee_item_if;
  import fee_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    cmd;
  logic [PIXEL_ADDR_W-1:0] pixel_address;
  modport source (output valid, cmd, pixel_address, input ready);
  modport sink   (input valid, cmd, pixel_address, output ready);
endinterface

interface fee_result_if;
  import fee_pkg::*;
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] pixel_color;
  logic               frame_done;
  modport source (output valid, pixel_color, frame_done, input ready);
  modport sink   (input valid, pixel_color, frame_done, output ready);
endinterface

interface fee_cfg_if;
  import fee_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/fee_ram.sv =====
// fee_ram: generic single-port ram, one read or write per cycle, registered read
// no dependencies
`default_nettype none

module fee_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fee_alu.sv =====
// fee_alu: shared arithmetic unit, tap accumulator, averaging with the
// zero-if-unchanged rule, and the mod 255 reduction of the random state; uses fee_pkg
`default_nettype none

module fee_alu import fee_pkg::*; (
  input  wire logic              clk,
  input  wire alu_ctrl_t         ctrl,
  input  wire logic [CELL_W-1:0] tap,
  input  wire logic [RNG_W-1:0]  rng,
  output logic      [CELL_W-1:0] cell_value,
  output logic      [CELL_W-1:0] seed_value
);

  logic [ACC_W-1:0]  acc;
  logic [CELL_W-1:0] old;
  logic [PROD_W-1:0] prod;
  logic [CELL_W-1:0] avg;
  logic [ACC_W-1:0]  byte_sum;
  logic [8:0]        fold;

  always_ff @(posedge clk) begin
    case (ctrl.op)
      ALU_LOAD: begin
        acc <= ACC_W'(tap);
        old <= tap;
      end
      ALU_ADD: begin
        acc <= acc + ACC_W'(tap);
      end
      default: begin
      end
    endcase
  end

  // divide by four is a shift, by three a reciprocal multiply
  always_comb begin
    prod = PROD_W'(acc) * PROD_W'(DIV3_MUL);
    avg  = ctrl.three_tap ? prod[DIV3_SHIFT +: CELL_W] : acc[ACC_W-1 -: CELL_W];
    cell_value = (avg == old) ? '0 : avg;
  end

  // 256 = 1 mod 255, so fold the bytes and correct once
  always_comb begin
    byte_sum = ACC_W'(rng[7:0]) + ACC_W'(rng[15:8]) + ACC_W'(rng[23:16])
             + ACC_W'(rng[31:24]);
    fold = 9'(byte_sum[ACC_W-1:8]) + 9'(byte_sum[7:0]);
    seed_value = (fold >= 9'd255) ? CELL_W'(fold - 9'd255) : fold[CELL_W-1:0];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fire_effect_frame_engine_core.sv =====
// fire_effect_frame_engine_core: top level, sequencer, heat grid memory and result register
// depends on fee_pkg, fee_if, fee_ram and fee_alu
`default_nettype none

// usage
//   items   : one word per command; cmd 0 advances one frame, cmd 1 reads the
//             palette color of the cell at pixel_address
//   results : one word per item; a read returns pixel_color with frame_done 0,
//             an advance returns color 0 with frame_done 1
//   cfg     : register writes (index 0 wind_offset, 1 initial_seed), ready
//             while idle or clearing; writing initial_seed also reloads the
//             random state
// timing
//   after reset a clearing pass zeroes every cell, one cell a cycle; items
//   are not accepted during it, config writes are
//   an advance seeds columns 1 to 238 of the bottom row (ST_SEED_MUL, then
//   ST_SEED_WR per cell), then updates the 57120 cells of rows 318 down to
//   81 in ST_RD_CELL, ST_RD_MID, ST_RD_A, ST_RD_B, ST_ACC and ST_WR, ST_RD_B
//   skipped for the three-tap average (wind set, not row 318); the single
//   port of the heat grid memory, one access per cycle, orders these steps
//   a read of a visible cell passes ST_PIX_RD and ST_PIX_CAP before ST_OUT,
//   a read above the visible area or past the grid goes straight to ST_OUT
//   items are taken only while the sequencer is idle; a finished result
//   waits in the output register while the next item is taken, and the
//   sequencer holds its next result until the receiver takes the previous one
module fire_effect_frame_engine_core import fee_pkg::*; (
  input wire logic   clk,
  input wire logic   rst,
  fee_item_if.sink   items,
  fee_result_if.source results,
  fee_cfg_if.sink    cfg
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEED_MUL,
    ST_SEED_WR,
    ST_RD_CELL,
    ST_RD_MID,
    ST_RD_A,
    ST_RD_B,
    ST_ACC,
    ST_WR,
    ST_PIX_RD,
    ST_PIX_CAP,
    ST_OUT
  } state_t;

  state_t                     state;
  logic [IDX_W-1:0]           idx;
  logic [X_W-1:0]             x;
  logic [Y_W-1:0]             y;
  logic signed [SADDR_W-1:0]  src;
  logic                       tap_ok;
  logic [RNG_W-1:0]           rng;
  logic signed [WIND_W-1:0]   wind;
  logic                       res_valid;
  logic [COLOR_W-1:0]         res_color;
  logic                       res_done;
  logic [COLOR_W-1:0]         pend_color;
  logic                       pend_done;

  // comb
  logic                       three_tap;
  logic signed [SADDR_W-1:0]  tap_addr;
  logic                       tap_in_grid;
  logic                       ram_we;
  logic [IDX_W-1:0]           ram_addr;
  logic [CELL_W-1:0]          ram_wdata;
  logic [CELL_W-1:0]          ram_rdata;
  logic [CELL_W-1:0]          tap_data;
  alu_ctrl_t                  alu_ctrl;
  logic [CELL_W-1:0]          cell_value;
  logic [CELL_W-1:0]          seed_value;
  logic [CMP_W-1:0]           pa_ext;
  logic                       pa_visible;
  logic                       res_load;

  assign items.ready         = (state == ST_IDLE);
  assign cfg.ready           = (state == ST_IDLE) || (state == ST_CLEAR);
  assign results.valid       = res_valid;
  assign results.pixel_color = res_color;
  assign results.frame_done  = res_done;

  // pending word moves to the output register once it is free
  assign res_load = (state == ST_OUT) && (!res_valid || results.ready);

  // second-lowest row always takes four taps: its own old value and three from the row below
  assign three_tap = (y != Y_W'(GRID_HEIGHT - 2)) && (wind != '0);

  // tap address for the source row, linear so columns wrap into the adjacent row
  always_comb begin
    case (state)
      ST_RD_A: tap_addr = three_tap ? (src - SADDR_W'(wind)) : (src - SADDR_W'(1));
      ST_RD_B: tap_addr = src + SADDR_W'(1);
      default: tap_addr = src;
    endcase
    tap_in_grid = (tap_addr >= 0) && (tap_addr < CELLS_S);
  end

  // off-grid taps read as zero
  assign tap_data = tap_ok ? ram_rdata : '0;

  assign pa_ext     = CMP_W'(items.pixel_address);
  assign pa_visible = (pa_ext >= CMP_W'(TOP_ROW * GRID_WIDTH)) && (pa_ext < CMP_W'(CELLS));

  // memory port and shared unit control
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = idx;
    ram_wdata = '0;
    alu_ctrl.op        = ALU_HOLD;
    alu_ctrl.three_tap = three_tap;
    case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_SEED_WR: begin
        ram_we    = 1'b1;
        ram_wdata = seed_value;
      end
      ST_RD_MID: begin
        ram_addr    = tap_addr[IDX_W-1:0];
        alu_ctrl.op = ALU_LOAD;
      end
      ST_RD_A, ST_RD_B: begin
        ram_addr    = tap_addr[IDX_W-1:0];
        alu_ctrl.op = ALU_ADD;
      end
      ST_ACC: begin
        alu_ctrl.op = ALU_ADD;
      end
      ST_WR: begin
        ram_we    = 1'b1;
        ram_wdata = cell_value;
      end
      default: begin
      end
    endcase
  end

  fee_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  fee_alu u_alu (
    .clk        (clk),
    .ctrl       (alu_ctrl),
    .tap        (tap_data),
    .rng        (rng),
    .cell_value (cell_value),
    .seed_value (seed_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      idx       <= '0;
      rng       <= '0;
      wind      <= '0;
      res_valid <= 1'b0;
      tap_ok    <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (results.ready) begin
        res_valid <= 1'b0;
      end

      case (state)
        // zero the grid after reset
        ST_CLEAR: begin
          if (idx == IDX_W'(CELLS - 1)) begin
            state <= ST_IDLE;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end

        ST_IDLE: begin
          if (items.valid) begin
            if (items.cmd == CMD_ADVANCE) begin
              idx   <= IDX_W'((GRID_HEIGHT - 1) * GRID_WIDTH + 1);
              x     <= X_W'(1);
              state <= ST_SEED_MUL;
            end else if (pa_visible) begin
              idx   <= IDX_W'(pa_ext);
              state <= ST_PIX_RD;
            end else begin
              pend_color <= '0;
              pend_done  <= 1'b0;
              state      <= ST_OUT;
            end
          end
        end

        // bottom row seeding, columns 1 to width-2
        ST_SEED_MUL: begin
          rng   <= rng * LCG_MUL + 32'd1;
          state <= ST_SEED_WR;
        end

        ST_SEED_WR: begin
          if (x == X_W'(GRID_WIDTH - 2)) begin
            x     <= '0;
            y     <= Y_W'(GRID_HEIGHT - 2);
            idx   <= IDX_W'((GRID_HEIGHT - 2) * GRID_WIDTH);
            state <= ST_RD_CELL;
          end else begin
            x     <= x + X_W'(1);
            idx   <= idx + IDX_W'(1);
            state <= ST_SEED_MUL;
          end
        end

        // per cell: read old value, then taps, accumulate, write back
        ST_RD_CELL: begin
          src    <= $signed({2'b00, idx}) + ((y == Y_W'(GRID_HEIGHT - 2))
                    ? SADDR_W'(GRID_WIDTH) : SADDR_W'(2 * GRID_WIDTH));
          tap_ok <= 1'b1;
          state  <= ST_RD_MID;
        end

        ST_RD_MID: begin
          tap_ok <= tap_in_grid;
          state  <= ST_RD_A;
        end

        ST_RD_A: begin
          tap_ok <= tap_in_grid;
          state  <= three_tap ? ST_ACC : ST_RD_B;
        end

        ST_RD_B: begin
          tap_ok <= tap_in_grid;
          state  <= ST_ACC;
        end

        ST_ACC: begin
          state <= ST_WR;
        end

        ST_WR: begin
          if (x == X_W'(GRID_WIDTH - 1)) begin
            if (y <= Y_W'(TOP_ROW + 1)) begin
              pend_color <= '0;
              pend_done  <= 1'b1;
              state      <= ST_OUT;
            end else begin
              x     <= '0;
              y     <= y - Y_W'(1);
              idx   <= idx - IDX_W'(2 * GRID_WIDTH - 1);
              state <= ST_RD_CELL;
            end
          end else begin
            x     <= x + X_W'(1);
            idx   <= idx + IDX_W'(1);
            state <= ST_RD_CELL;
          end
        end

        // display read
        ST_PIX_RD: begin
          state <= ST_PIX_CAP;
        end

        ST_PIX_CAP: begin
          pend_color <= palette(ram_rdata);
          pend_done  <= 1'b0;
          state      <= ST_OUT;
        end

        // hand the word to the output register once it is free
        ST_OUT: begin
          if (res_load) begin
            res_color <= pend_color;
            res_done  <= pend_done;
            state     <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase

      // register writes, taken only while idle or clearing
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_WIND_OFFSET:  wind <= cfg.data[WIND_W-1:0];
          CFG_INITIAL_SEED: rng  <= cfg.data[RNG_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire
